// ===== rtl/core/sma_pkg.sv =====
// Shared types and codes for the split/merge block allocator.
// No dependencies; used by sma_seq and split_merge_block_allocator.
package sma_pkg;

  // pool size is tied to the 12-bit offset and size fields
  localparam int POOL_BYTES = 4096;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;
  localparam logic [1:0] OP_REINIT  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_BAD_BLK  = 2'd2;
  localparam logic [1:0] ST_NOT_USED = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] payload_offset;
    logic [11:0] payload_bytes;
  } result_t;

endpackage

// ===== rtl/core/sma_table.sv =====
// Block header table: one synchronous memory, one write and one read port.
// Word is {used, size}; read data is registered and appears in the cycle after the address.
module sma_table #(
  parameter int AW = 7,
  parameter int DW = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [DW-1:0] wd,
  input  logic          re,
  input  logic [AW-1:0] ra,
  output logic [DW-1:0] rd
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule

// ===== rtl/core/sma_seq.sv =====
// Sequencer: walks, splits and merges block headers held in sma_table.
// Depends on sma_pkg and sma_table.
module sma_seq #(
  parameter int HEADER_BYTES = 8,
  parameter int SLOT_BYTES   = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        opcode,
  input  logic [12:0]       request_bytes,
  input  logic [11:0]       release_offset,
  input  logic [11:0]       min_payload,
  input  logic              take,
  output logic              idle,
  output logic              done,
  output sma_pkg::result_t  res
);

  localparam int POOL_BYTES = sma_pkg::POOL_BYTES;
  localparam int DEPTH = POOL_BYTES / SLOT_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SH    = $clog2(SLOT_BYTES);
  localparam int SZW   = $clog2(POOL_BYTES) + 1;
  localparam int CW    = AW + 2;
  localparam int DW    = SZW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_WK   = 4'd3;
  localparam logic [3:0] S_SPL  = 4'd4;
  localparam logic [3:0] S_JRH  = 4'd5;
  localparam logic [3:0] S_JEH  = 4'd6;
  localparam logic [3:0] S_JEN  = 4'd7;
  localparam logic [3:0] S_JWN  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]     state_r, state_nxt;
  logic [1:0]     op_r, op_nxt;
  logic [13:0]    need_r, need_nxt;
  logic [CW-1:0]  s_r, s_nxt;        // walk / merge head slot
  logic [CW-1:0]  n_r, n_nxt;        // merge neighbor slot
  logic [CW-1:0]  slot_r, slot_nxt;  // release target
  logic [CW-1:0]  best_r, best_nxt;
  logic           best_v_r, best_v_nxt;
  logic [SZW-1:0] cur_sz_r, cur_sz_nxt;
  logic           uh_r, uh_nxt;
  logic           chg_r, chg_nxt;
  logic           clr_reply_r, clr_reply_nxt;
  sma_pkg::result_t res_r, res_nxt;

  logic           we, re;
  logic [AW-1:0]  wa, ra;
  logic [DW-1:0]  wd, rdata;
  logic [SZW-1:0] d_sz, half;
  logic           d_used;
  logic [CW-1:0]  d_step;
  logic [11:0]    rel_start;
  logic [12:0]    req_eff;

  sma_table #(.AW(AW), .DW(DW)) u_table (
    .clk(clk), .we(we), .wa(wa), .wd(wd), .re(re), .ra(ra), .rd(rdata)
  );

  assign d_sz   = rdata[SZW-1:0];
  assign d_used = rdata[SZW];
  assign d_step = CW'(d_sz >> SH);
  assign half   = cur_sz_r >> 1;
  assign rel_start = release_offset - 12'(HEADER_BYTES);
  assign req_eff = (request_bytes < {1'b0, min_payload}) ? {1'b0, min_payload}
                                                         : request_bytes;

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE);
  assign res  = res_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    need_nxt      = need_r;
    s_nxt         = s_r;
    n_nxt         = n_r;
    slot_nxt      = slot_r;
    best_nxt      = best_r;
    best_v_nxt    = best_v_r;
    cur_sz_nxt    = cur_sz_r;
    uh_nxt        = uh_r;
    chg_nxt       = chg_r;
    clr_reply_nxt = clr_reply_r;
    res_nxt       = res_r;
    we = 1'b0;
    wa = s_r[AW-1:0];
    wd = '0;
    re = 1'b0;
    ra = s_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = opcode;
          need_nxt   = 14'(req_eff) + 14'(HEADER_BYTES);
          s_nxt      = '0;
          best_v_nxt = 1'b0;
          res_nxt    = '0;
          slot_nxt   = CW'(rel_start >> SH);
          case (opcode)
            sma_pkg::OP_REINIT: begin
              clr_reply_nxt = 1'b1;
              state_nxt     = S_CLR;
            end
            sma_pkg::OP_RELEASE: begin
              if (release_offset < 12'(HEADER_BYTES) ||
                  32'(rel_start) >= 32'(POOL_BYTES) ||
                  (rel_start & 12'(SLOT_BYTES - 1)) != 12'd0) begin
                res_nxt.status = sma_pkg::ST_BAD_BLK;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_RD;
              end
            end
            default: state_nxt = S_RD;
          endcase
        end
      end
      S_CLR: begin
        we = 1'b1;
        wa = s_r[AW-1:0];
        wd = (s_r == '0) ? DW'(POOL_BYTES) : '0;
        s_nxt = s_r + 1'b1;
        if (s_r == CW'(DEPTH - 1)) begin
          state_nxt = clr_reply_r ? S_DONE : S_IDLE;
        end
      end
      S_RD: begin
        if (s_r >= CW'(DEPTH)) begin
          // walk ran off the table
          case (op_r)
            sma_pkg::OP_RELEASE: begin
              res_nxt.status = sma_pkg::ST_BAD_BLK;
              state_nxt      = S_DONE;
            end
            sma_pkg::OP_ACQUIRE: begin
              if (best_v_r) begin
                state_nxt = S_SPL;
              end else begin
                res_nxt.status = sma_pkg::ST_NO_FIT;
                state_nxt      = S_DONE;
              end
            end
            default: begin
              res_nxt.status = best_v_r ? sma_pkg::ST_OK : sma_pkg::ST_NO_FIT;
              state_nxt      = S_DONE;
            end
          endcase
        end else begin
          re = 1'b1;
          ra = s_r[AW-1:0];
          state_nxt = S_WK;
        end
      end
      S_WK: begin
        if (op_r == sma_pkg::OP_RELEASE && s_r == slot_r) begin
          if (!d_used) begin
            res_nxt.status = sma_pkg::ST_NOT_USED;
            state_nxt      = S_DONE;
          end else begin
            we = 1'b1;
            wa = s_r[AW-1:0];
            wd = {1'b0, d_sz};
            s_nxt     = '0;
            chg_nxt   = 1'b0;
            state_nxt = S_JRH;
          end
        end else if (32'(d_sz) < 32'(SLOT_BYTES)) begin
          s_nxt     = CW'(DEPTH);   // ends the walk
          state_nxt = S_RD;
        end else begin
          if (!d_used && 32'(d_sz) >= 32'(need_r) &&
              (!best_v_r || cur_sz_r > d_sz)) begin
            best_v_nxt = 1'b1;
            best_nxt   = s_r;
            cur_sz_nxt = d_sz;
          end
          s_nxt     = s_r + d_step;
          state_nxt = S_RD;
        end
      end
      S_SPL: begin
        if (32'(need_r) <= 32'(half) && 32'(half) >= 32'(SLOT_BYTES)) begin
          we = 1'b1;
          wa = AW'(best_r + CW'(half >> SH));
          wd = {1'b0, half};
          cur_sz_nxt = half;
        end else begin
          we = 1'b1;
          wa = best_r[AW-1:0];
          wd = {1'b1, cur_sz_r};
          res_nxt.status         = sma_pkg::ST_OK;
          res_nxt.payload_offset = 12'((32'(best_r) << SH) + 32'(HEADER_BYTES));
          res_nxt.payload_bytes  = 12'(32'(cur_sz_r) - 32'(HEADER_BYTES));
          state_nxt = S_DONE;
        end
      end
      S_JRH: begin
        if (s_r >= CW'(DEPTH)) begin
          // end of pass
          if (chg_r) begin
            chg_nxt = 1'b0;
            s_nxt   = '0;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          re = 1'b1;
          ra = s_r[AW-1:0];
          state_nxt = S_JEH;
        end
      end
      S_JEH: begin
        cur_sz_nxt = d_sz;
        uh_nxt     = d_used;
        n_nxt      = s_r + d_step;
        if (32'(d_sz) < 32'(SLOT_BYTES) || s_r + d_step >= CW'(DEPTH)) begin
          s_nxt     = CW'(DEPTH);
          state_nxt = S_JRH;
        end else begin
          re = 1'b1;
          ra = AW'(s_r + d_step);
          state_nxt = S_JEN;
        end
      end
      S_JEN: begin
        if (d_sz == cur_sz_r) begin
          if (uh_r || d_used) begin
            s_nxt     = n_r + d_step;
            state_nxt = S_JRH;
          end else begin
            we = 1'b1;
            wa = s_r[AW-1:0];
            wd = {1'b0, SZW'(cur_sz_r << 1)};
            chg_nxt   = 1'b1;
            state_nxt = S_JWN;
          end
        end else begin
          s_nxt     = n_r;
          state_nxt = S_JRH;
        end
      end
      S_JWN: begin
        we = 1'b1;
        wa = n_r[AW-1:0];
        wd = '0;
        state_nxt = S_JRH;
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      s_r         <= '0;
      clr_reply_r <= 1'b0;
      chg_r       <= 1'b0;
      best_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s_r         <= s_nxt;
      clr_reply_r <= clr_reply_nxt;
      chg_r       <= chg_nxt;
      best_v_r    <= best_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    need_r   <= need_nxt;
    n_r      <= n_nxt;
    slot_r   <= slot_nxt;
    best_r   <= best_nxt;
    cur_sz_r <= cur_sz_nxt;
    uh_r     <= uh_nxt;
    res_r    <= res_nxt;
  end

endmodule

// ===== rtl/core/split_merge_block_allocator.sv =====
// Split/merge block allocator top level: config register, output register.
// Depends on sma_pkg and sma_seq (which holds the header table).
//
// Usage: in_valid/in_ready carry one item (opcode, request_bytes,
// release_offset); out_valid/out_ready carry exactly one result per item.
// cfg_we writes min_payload in the same cycle; the user must write it only
// while idle, as the block itself does not enforce this.
// One item is worked at a time; a walk reads each block header it visits:
//   query and failed acquire: one walk;
//   granted acquire: one walk, then a step per split and a header write;
//   release: a walk to find it, then merge passes over the block heads,
//   joining blocks, repeated until a pass joins nothing;
//   reinitialize: a sweep over all POOL_BYTES/SLOT_BYTES table entries.
// After reset the same table sweep runs with in_ready low. A finished
// result sits in the output register; a stalled receiver holds it there,
// and the next item may be accepted and worked, finishing only once the
// register is free.
module split_merge_block_allocator #(
  parameter int HEADER_BYTES = 8,
  parameter int SLOT_BYTES   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [12:0] in_request_bytes,
  input  logic [11:0] in_release_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [11:0] out_payload_offset,
  output logic [11:0] out_payload_bytes,
  input  logic        cfg_we,
  input  logic [11:0] cfg_min_payload
);

  logic [11:0] min_payload_r;
  logic        out_valid_r;
  sma_pkg::result_t out_r, seq_res;
  logic        seq_idle, seq_done, take;

  assign take     = seq_done && (!out_valid_r || out_ready);
  assign in_ready = seq_idle;

  sma_seq #(
    .HEADER_BYTES(HEADER_BYTES), .SLOT_BYTES(SLOT_BYTES)
  ) u_seq (
    .clk(clk), .rst_n(rst_n),
    .start(in_valid && seq_idle),
    .opcode(in_opcode), .request_bytes(in_request_bytes),
    .release_offset(in_release_offset), .min_payload(min_payload_r),
    .take(take), .idle(seq_idle), .done(seq_done), .res(seq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_payload_r <= 12'd8;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_payload_r <= cfg_min_payload;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= seq_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_payload_offset = out_r.payload_offset;
  assign out_payload_bytes  = out_r.payload_bytes;

endmodule

// ===== tb/tb_split_merge_block_allocator.sv =====
// Self-checking bench for split_merge_block_allocator: an internal table model
// predicts every item's result, checked in order. Depends on sma_pkg and the RTL.
module tb_split_merge_block_allocator;

  localparam int POOL  = 4096;
  localparam int HDR   = 8;
  localparam int SLOT  = 32;
  localparam int NSLOT = POOL / SLOT;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct {
    logic [1:0]  op;
    logic [12:0] req;
    logic [11:0] off;
  } alloc_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = '0;
  logic [12:0] in_request_bytes = '0;
  logic [11:0] in_release_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [11:0] out_payload_offset;
  logic [11:0] out_payload_bytes;
  logic cfg_we = 1'b0;
  logic [11:0] cfg_min_payload = 12'd8;

  split_merge_block_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_request_bytes(in_request_bytes),
    .in_release_offset(in_release_offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_payload_offset(out_payload_offset),
    .out_payload_bytes(out_payload_bytes),
    .cfg_we(cfg_we), .cfg_min_payload(cfg_min_payload)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  int unsigned blk_size[NSLOT];
  bit blk_used[NSLOT];
  int unsigned min_pay;

  alloc_req_t pending_items[$];
  sma_pkg::result_t expected_results[$];
  int mismatches = 0;
  bit failed = 0;
  bit idle_on = 1;
  bit stim_done = 0;
  int quiet_cycles = 0;

  function automatic void pool_clear();
    for (int i = 0; i < NSLOT; i++) begin
      blk_size[i] = 0;
      blk_used[i] = 0;
    end
    blk_size[0] = POOL;
  endfunction

  function automatic int best_fit(int unsigned need);
    int s, best;
    s = 0;
    best = NSLOT;
    while (s < NSLOT) begin
      if (blk_size[s] < SLOT) break;
      if (!blk_used[s] && blk_size[s] >= need &&
          (best == NSLOT || blk_size[best] > blk_size[s]))
        best = s;
      s += blk_size[s] / SLOT;
    end
    return best;
  endfunction

  function automatic int unsigned need_of(int unsigned req);
    return ((req < min_pay) ? min_pay : req) + HDR;
  endfunction

  function automatic bit on_chain(int slot);
    int s;
    s = 0;
    while (s < NSLOT) begin
      if (s == slot) return 1;
      if (blk_size[s] < SLOT) break;
      s += blk_size[s] / SLOT;
    end
    return 0;
  endfunction

  function automatic void coalesce();
    bit changed;
    int h, n;
    changed = 1;
    while (changed) begin
      changed = 0;
      h = 0;
      while (h < NSLOT) begin
        if (blk_size[h] < SLOT) break;
        n = h + blk_size[h] / SLOT;
        if (n >= NSLOT) break;
        if (blk_size[n] == blk_size[h]) begin
          if (blk_used[h] || blk_used[n]) begin
            h = n + blk_size[n] / SLOT;
          end else begin
            blk_size[h] = 2 * blk_size[h];
            blk_size[n] = 0;
            blk_used[n] = 0;
            changed = 1;
          end
        end else begin
          h = n;
        end
      end
    end
  endfunction

  function automatic sma_pkg::result_t predict_alloc(alloc_req_t it);
    sma_pkg::result_t r;
    int unsigned need, sz, half, start;
    int s, n;
    r = '0;
    case (it.op)
      sma_pkg::OP_ACQUIRE: begin
        need = need_of(it.req);
        s = best_fit(need);
        if (s == NSLOT) begin
          r.status = sma_pkg::ST_NO_FIT;
        end else begin
          sz = blk_size[s];
          half = sz / 2;
          while (need <= half && half >= SLOT) begin
            n = s + half / SLOT;
            if (n < NSLOT) begin
              blk_size[n] = sz - half;
              blk_used[n] = 0;
            end
            sz = half;
            half = half / 2;
          end
          blk_size[s] = sz;
          blk_used[s] = 1;
          r.payload_offset = 12'(s * SLOT + HDR);
          r.payload_bytes = 12'(sz - HDR);
        end
      end
      sma_pkg::OP_RELEASE: begin
        if (it.off < HDR) begin
          r.status = sma_pkg::ST_BAD_BLK;
        end else begin
          start = it.off - HDR;
          if (start >= POOL || start % SLOT != 0 || !on_chain(start / SLOT))
            r.status = sma_pkg::ST_BAD_BLK;
          else if (!blk_used[start / SLOT])
            r.status = sma_pkg::ST_NOT_USED;
          else begin
            blk_used[start / SLOT] = 0;
            coalesce();
          end
        end
      end
      sma_pkg::OP_QUERY: begin
        if (best_fit(need_of(it.req)) == NSLOT) r.status = sma_pkg::ST_NO_FIT;
      end
      default: pool_clear();
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_alloc(pending_items.pop_front()));
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && !(idle_on && $urandom_range(99) < 20)) begin
          in_valid <= 1'b1;
          in_opcode <= pending_items[0].op;
          in_request_bytes <= pending_items[0].req;
          in_release_offset <= pending_items[0].off;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          failed = 1;
          if (mismatches < 10) $display("unexpected result status=%0d", out_status);
          mismatches++;
        end else begin
          sma_pkg::result_t e;
          e = expected_results.pop_front();
          if (e.status !== out_status || e.payload_offset !== out_payload_offset ||
              e.payload_bytes !== out_payload_bytes) begin
            failed = 1;
            if (mismatches < 10)
              $display("mismatch: exp st=%0d off=%0d bytes=%0d got st=%0d off=%0d bytes=%0d",
                       e.status, e.payload_offset, e.payload_bytes,
                       out_status, out_payload_offset, out_payload_bytes);
            mismatches++;
          end
        end
      end
      out_ready <= !(idle_on && $urandom_range(99) < 20);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_item(logic [1:0] op, logic [12:0] req, logic [11:0] off);
    alloc_req_t it;
    it.op = op;
    it.req = req;
    it.off = off;
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_min_payload(logic [11:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_min_payload <= v;
    min_pay = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly acquires and releases; release offsets favor slot-aligned starts
  task automatic random_phase(int count);
    int k;
    logic [11:0] off;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 40) begin
        add_item(sma_pkg::OP_ACQUIRE, ($urandom_range(9) == 0) ? 13'($urandom_range(8191))
                 : 13'($urandom_range(600)), 12'($urandom));
      end else if (k < 80) begin
        if ($urandom_range(9) < 7 && i > 0)
          off = 12'(SLOT * $urandom_range(NSLOT - 1) + HDR);
        else
          off = 12'($urandom);
        add_item(sma_pkg::OP_RELEASE, 13'($urandom), off);
      end else if (k < 96) begin
        add_item(sma_pkg::OP_QUERY, 13'($urandom_range(8191)), 12'($urandom));
      end else begin
        add_item(sma_pkg::OP_REINIT, 13'($urandom), 12'($urandom));
      end
    end
  endtask

  initial begin
    pool_clear();
    min_pay = 8;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes and each special case
    add_item(sma_pkg::OP_QUERY, 13'd4096, 12'd0);       // oversized query
    add_item(sma_pkg::OP_ACQUIRE, 13'd4096, 12'd0);     // oversized acquire
    add_item(sma_pkg::OP_ACQUIRE, 13'd4088, 12'd0);     // whole pool
    add_item(sma_pkg::OP_ACQUIRE, 13'd0, 12'd0);        // no fit
    add_item(sma_pkg::OP_RELEASE, 13'd0, 12'd8);
    add_item(sma_pkg::OP_RELEASE, 13'd0, 12'd8);        // free block
    add_item(sma_pkg::OP_RELEASE, 13'd0, 12'd0);        // below header
    add_item(sma_pkg::OP_RELEASE, 13'd0, 12'd4095);     // not a block
    add_item(sma_pkg::OP_RELEASE, 13'd0, 12'd40);       // inside a block
    add_item(sma_pkg::OP_ACQUIRE, 13'd0, 12'd0);        // smallest block
    add_item(sma_pkg::OP_ACQUIRE, 13'd24, 12'd0);
    add_item(sma_pkg::OP_ACQUIRE, 13'd25, 12'd0);
    add_item(sma_pkg::OP_ACQUIRE, 13'd100, 12'd0);
    add_item(sma_pkg::OP_RELEASE, 13'd0, 12'd40);       // non-buddy merges
    add_item(sma_pkg::OP_RELEASE, 13'd0, 12'd8);
    add_item(sma_pkg::OP_QUERY, 13'd8191, 12'd0);
    add_item(sma_pkg::OP_QUERY, 13'd0, 12'd0);
    add_item(sma_pkg::OP_REINIT, 13'h1FFF, 12'hFFF);
    add_item(sma_pkg::OP_ACQUIRE, 13'h1FFF, 12'hFFF);
    wait_drained();

    set_min_payload(12'd4088);
    add_item(sma_pkg::OP_ACQUIRE, 13'd0, 12'd0);
    add_item(sma_pkg::OP_ACQUIRE, 13'd0, 12'd0);
    add_item(sma_pkg::OP_QUERY, 13'd1, 12'd0);
    add_item(sma_pkg::OP_REINIT, 13'd0, 12'd0);
    random_phase(60);
    wait_drained();

    set_min_payload(12'd8);
    idle_on = 0;                               // no-idle stretch
    random_phase(200);
    wait_drained();
    idle_on = 1;

    set_min_payload(12'hAAA);
    random_phase(60);
    wait_drained();

    set_min_payload(12'd100);
    random_phase(250);
    wait_drained();

    set_min_payload(12'h555);
    random_phase(40);
    wait_drained();

    set_min_payload(12'd8);
    random_phase(200);
    wait_drained();

    if (!failed && expected_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
